/* sv/brd_pkg.sv */
`default_nettype none
package brd_pkg;

  localparam int DEPTH = 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 8;
  localparam int IW    = 8;
  localparam int OCCW  = 9;
  // common width for offset compare and occupancy extraction
  localparam int XW    = (CW > IW) ? ((CW > OCCW) ? CW : OCCW) : ((IW > OCCW) ? IW : OCCW);

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_WRITE      = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load;  // capture the incoming command
    logic exec;  // do the store access and update head/count
  } ctl_t;

  // (a + b) mod DEPTH, both operands below DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW + 1)'(DEPTH)) begin
      sum = sum - (AW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage
`default_nettype wire

/* sv/brd_ram.sv */
`default_nettype none
module brd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

/* sv/brd_ctrl.sv */
`default_nettype none
module brd_ctrl
  import brd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output ctl_t      ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        // a new item may come in on the cycle the result transfers
        in_stall  = out_stall;
        if (!out_stall) begin
          if (in_valid) begin
            ctl.load   = 1'b1;
            state_next = S_EXEC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/brd_dp.sv */
`default_nettype none
module brd_dp
  import brd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ctl_t             ctl,
  input  wire logic [2:0]       op,
  input  wire logic [DW-1:0]    data_in,
  input  wire logic [IW-1:0]    index,
  output logic      [DW-1:0]    data_out,
  output logic      [1:0]       status,
  output logic      [OCCW-1:0]  occupancy
);

  // command register
  logic [2:0]    cmd_op;
  logic [DW-1:0] cmd_data;
  logic [IW-1:0] cmd_index;

  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;

  status_t       st_q, st;
  logic          rd_q, rd;

  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_rdata;

  logic [XW-1:0] idx_x, cnt_x, occ_x;
  logic [AW-1:0] off;
  logic          is_full, is_empty, in_range;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_op    <= op;
      cmd_data  <= data_in;
      cmd_index <= index;
    end
  end

  assign idx_x    = XW'(cmd_index);
  assign cnt_x    = XW'(count);
  assign off      = idx_x[AW-1:0];
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign in_range = (idx_x < cnt_x);

  always_comb begin
    head_next  = head;
    count_next = count;
    st         = ST_OK;
    rd         = 1'b0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = head;
    unique case (cmd_op)
      OP_PUSH_BACK: begin
        if (is_full) begin
          st = ST_FULL;
        end else begin
          ram_en     = 1'b1;
          ram_we     = 1'b1;
          ram_addr   = wrap_add(head, count[AW-1:0]);
          count_next = count + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (is_full) begin
          st = ST_FULL;
        end else begin
          head_next  = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
          ram_en     = 1'b1;
          ram_we     = 1'b1;
          ram_addr   = head_next;
          count_next = count + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
          ram_en     = 1'b1;
          ram_addr   = wrap_add(head, count_next[AW-1:0]);
          rd         = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          st = ST_EMPTY;
        end else begin
          ram_en     = 1'b1;
          ram_addr   = head;
          rd         = 1'b1;
          head_next  = (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
          count_next = count - 1'b1;
        end
      end
      OP_READ: begin
        if (!in_range) begin
          st = ST_RANGE;
        end else begin
          ram_en   = 1'b1;
          ram_addr = wrap_add(head, off);
          rd       = 1'b1;
        end
      end
      OP_WRITE: begin
        if (!in_range) begin
          st = ST_RANGE;
        end else begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = wrap_add(head, off);
        end
      end
      OP_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rd_q  <= 1'b0;
    end else if (ctl.exec) begin
      head  <= head_next;
      count <= count_next;
      rd_q  <= rd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      st_q <= st;
    end
  end

  brd_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en && ctl.exec),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cmd_data),
    .rdata (ram_rdata)
  );

  // read data stays put in the RAM output register until the next read access
  assign data_out  = rd_q ? ram_rdata : '0;
  assign status    = st_q;
  assign occ_x     = XW'(count);
  assign occupancy = occ_x[OCCW-1:0];

endmodule
`default_nettype wire

/* sv/byte_ring_deque_top.sv */
`default_nettype none
// Byte deque of DEPTH (256) entries in a circular single-port RAM, tracked by a
// head pointer and a fill count. Each transfer on the input channel performs one
// operation (push/pop at either end, read/write at an offset from head, clear)
// and produces exactly one result: the popped or read byte, a status code and
// the occupancy after the operation. An item passes through capture, RAM access
// and result in turn; a new item is accepted no earlier than the cycle in which
// the previous result transfers. Refused operations (empty, full, offset out of
// range) leave all state unchanged.
module byte_ring_deque_top
  import brd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [2:0]      op,
  input  wire logic [DW-1:0]   data_in,
  input  wire logic [IW-1:0]   index,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic      [DW-1:0]   data_out,
  output logic      [1:0]      status,
  output logic      [OCCW-1:0] occupancy
);

  ctl_t ctl;

  brd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  brd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .op        (op),
    .data_in   (data_in),
    .index     (index),
    .data_out  (data_out),
    .status    (status),
    .occupancy (occupancy)
  );

  a_refused_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> data_out == '0)
    else $error("refused operation returned data");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> occupancy == '0)
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> occupancy == OCCW'(DEPTH))
    else $error("full status with occupancy below capacity");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(occupancy) && $stable(status))
    else $error("stalled result changed");

endmodule
`default_nettype wire
